### hw/rtl/ida_pkg.sv
package ida_pkg;

    // samples per decision and frame layout
    localparam int SAMPLES_PER_DECISION = 10;
    localparam int FRAME_BYTES          = 13;

    localparam int SAMPLE_W = 12;
    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 16;
    localparam int COUNT_W  = $clog2(SAMPLES_PER_DECISION + 1);
    localparam int POS_W    = 5;
    localparam int TARGET_W = 14;
    localparam int SLOPE_W  = 10;
    localparam int DIR_W    = 2;

    localparam int DEADBAND_W = 8;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd5;
    localparam logic [GAIN_W-1:0]     GAIN_RST     = 16'd5073;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 24'd5153620;

    // item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FRAME  = 1'b1;

    // motor commands
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // frame decoding
    localparam logic [POS_W-1:0]  POS_MAX          = 5'd31;
    localparam logic [POS_W-1:0]  POS_OPCODE       = 5'd4;
    localparam logic [POS_W-1:0]  POS_SLOPE_LOW    = 5'd9;
    localparam logic [POS_W-1:0]  POS_SLOPE_HIGH   = 5'd10;
    localparam logic [POS_W-1:0]  POS_FRAME_END    = POS_W'(FRAME_BYTES);
    localparam logic [BYTE_W-1:0] OPCODE_SET_SLOPE = 8'h33;
    localparam int                SLOPE_BIAS       = 2000;

    // division by a constant through a reciprocal multiply
    localparam int DIV_SHIFT   = 21;
    localparam int AVG_RECIP_W = 22;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((2 ** DIV_SHIFT) + SAMPLES_PER_DECISION - 1) / SAMPLES_PER_DECISION);
    localparam int FRAME_DIV     = 10;
    localparam int FRAME_RECIP_W = 18;
    localparam logic [FRAME_RECIP_W-1:0] FRAME_RECIP =
        FRAME_RECIP_W'(((2 ** DIV_SHIFT) + FRAME_DIV - 1) / FRAME_DIV);

    // scaling arithmetic
    localparam int FRAC_W = 16;
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int NOW_W  = PROD_W - FRAC_W;
    localparam int DIFF_W = NOW_W + 1;
    localparam logic signed [NOW_W-1:0] NOW_MAX = NOW_W'((2 ** (SLOPE_W - 1)) - 1);
    localparam logic signed [NOW_W-1:0] NOW_MIN = -NOW_W'(2 ** (SLOPE_W - 1));

    typedef struct packed {
        logic [SUM_W-1:0]           sum;
        logic signed [TARGET_W-1:0] target;
    } acc_t;

    typedef struct packed {
        logic [SUM_W-1:0]           avg;
        logic signed [TARGET_W-1:0] target;
    } avg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]   prod;
        logic signed [TARGET_W-1:0] target;
    } scale_t;

endpackage

### hw/rtl/ida_frame.sv
module ida_frame
    import ida_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [BYTE_W-1:0]          frame_byte,
    input  logic                       frame_last,
    output logic signed [TARGET_W-1:0] target
);

    logic [POS_W-1:0]                 pos_reg;
    logic [POS_W-1:0]                 pos_next;
    logic [POS_W-1:0]                 pos_inc;
    logic [BYTE_W-1:0]                opcode_reg;
    logic [BYTE_W-1:0]                low_reg;
    logic [BYTE_W-1:0]                high_reg;
    logic signed [TARGET_W-1:0]       target_reg;
    logic signed [TARGET_W-1:0]       target_next;
    logic [2*BYTE_W-1:0]              raw;
    logic [2*BYTE_W+FRAME_RECIP_W-1:0] quot_prod;
    logic [TARGET_W-2:0]              quot;
    logic                             hit;

    always_comb
    begin
        pos_inc     = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        pos_next    = frame_last ? '0 : pos_inc;
        raw         = {high_reg, low_reg};
        quot_prod   = (2*BYTE_W+FRAME_RECIP_W)'(raw) * (2*BYTE_W+FRAME_RECIP_W)'(FRAME_RECIP);
        quot        = quot_prod[DIV_SHIFT +: TARGET_W-1];
        hit         = frame_last && (pos_inc == POS_FRAME_END) && (opcode_reg == OPCODE_SET_SLOPE);
        target_next = hit ? $signed({1'b0, quot}) - $signed(TARGET_W'(SLOPE_BIAS)) : target_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            opcode_reg <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            target_reg <= '0;
        end
        else if (take)
        begin
            pos_reg    <= pos_next;
            target_reg <= target_next;
            if (pos_reg == POS_OPCODE)
            begin
                opcode_reg <= frame_byte;
            end
            if (pos_reg == POS_SLOPE_LOW)
            begin
                low_reg <= frame_byte;
            end
            if (pos_reg == POS_SLOPE_HIGH)
            begin
                high_reg <= frame_byte;
            end
        end
    end

    assign target = target_reg;

endmodule

### hw/rtl/ida_accum.sv
module ida_accum
    import ida_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [SAMPLE_W-1:0]        sample,
    input  logic signed [TARGET_W-1:0] target,
    output logic                       free,
    output logic                       acc_valid,
    input  logic                       acc_ready,
    output acc_t                       acc_data
);

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_add;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_inc;
    logic               done;
    logic               valid_reg;
    acc_t               data_reg;

    always_comb
    begin
        sum_add = sum_reg + SUM_W'(sample);
        cnt_inc = cnt_reg + COUNT_W'(1);
        done    = (cnt_inc == COUNT_W'(SAMPLES_PER_DECISION));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take && done)
            begin
                sum_reg   <= '0;
                cnt_reg   <= '0;
                valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    sum_reg <= sum_add;
                    cnt_reg <= cnt_inc;
                end
                if (acc_ready)
                begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

    // group result, no reset needed
    always_ff @(posedge clk)
    begin
        if (take && done)
        begin
            data_reg.sum    <= sum_add;
            data_reg.target <= target;
        end
    end

    assign free      = !valid_reg || acc_ready;
    assign acc_valid = valid_reg;
    assign acc_data  = data_reg;

endmodule

### hw/rtl/ida_scale.sv
module ida_scale
    import ida_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc_valid,
    output logic                acc_ready,
    input  acc_t                acc_data,
    input  logic [GAIN_W-1:0]   gain_q16,
    input  logic [OFFSET_W-1:0] offset_q16,
    output logic                scl_valid,
    input  logic                scl_ready,
    output scale_t              scl_data
);

    logic                          avg_valid_reg;
    avg_t                          avg_reg;
    logic                          prod_valid_reg;
    scale_t                        prod_reg;
    logic                          avg_free;
    logic                          prod_free;
    logic [SUM_W+AVG_RECIP_W-1:0]  div_prod;
    logic [SUM_W+GAIN_W-1:0]       gain_prod;
    logic signed [PROD_W-1:0]      prod_next;

    assign prod_free = !prod_valid_reg || scl_ready;
    assign avg_free  = !avg_valid_reg || prod_free;

    always_comb
    begin
        // sum / SAMPLES_PER_DECISION
        div_prod  = (SUM_W+AVG_RECIP_W)'(acc_data.sum) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);
        // avg * gain - offset, Q16
        gain_prod = (SUM_W+GAIN_W)'(avg_reg.avg) * (SUM_W+GAIN_W)'(gain_q16);
        prod_next = $signed({1'b0, gain_prod}) - $signed(PROD_W'(offset_q16));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (avg_free)
            begin
                avg_valid_reg <= acc_valid;
            end
            if (prod_free)
            begin
                prod_valid_reg <= avg_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_free && acc_valid)
        begin
            avg_reg.avg    <= div_prod[DIV_SHIFT +: SUM_W];
            avg_reg.target <= acc_data.target;
        end
        if (prod_free && avg_valid_reg)
        begin
            prod_reg.prod   <= prod_next;
            prod_reg.target <= avg_reg.target;
        end
    end

    assign acc_ready = avg_free;
    assign scl_valid = prod_valid_reg;
    assign scl_data  = prod_reg;

endmodule

### hw/rtl/ida_decide.sv
module ida_decide
    import ida_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       scl_valid,
    output logic                       scl_ready,
    input  scale_t                     scl_data,
    input  logic [DEADBAND_W-1:0]      deadband,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [DIR_W-1:0]           res_dir,
    output logic signed [SLOPE_W-1:0]  res_slope,
    output logic signed [TARGET_W-1:0] res_target
);

    logic                       valid_reg;
    logic [DIR_W-1:0]           dir_reg;
    logic [DIR_W-1:0]           dir_next;
    logic signed [SLOPE_W-1:0]  slope_reg;
    logic signed [SLOPE_W-1:0]  slope_next;
    logic signed [TARGET_W-1:0] target_reg;
    logic                       neg;
    logic [PROD_W-1:0]          mag;
    logic [NOW_W-1:0]           mag_sh;
    logic signed [NOW_W-1:0]    now;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   db;
    logic                       free;

    assign free = !valid_reg || res_ready;

    always_comb
    begin
        // truncate toward zero
        neg    = scl_data.prod[PROD_W-1];
        mag    = neg ? (~scl_data.prod + PROD_W'(1)) : scl_data.prod;
        mag_sh = mag[PROD_W-1:FRAC_W];
        now    = neg ? -$signed(mag_sh) : $signed(mag_sh);

        diff = DIFF_W'(scl_data.target) - DIFF_W'(now);
        db   = $signed(DIFF_W'(deadband));
        if (diff > db)
        begin
            dir_next = DIR_UP;
        end
        else if (diff < -db)
        begin
            dir_next = DIR_DOWN;
        end
        else
        begin
            dir_next = DIR_STOP;
        end

        if (now > NOW_MAX)
        begin
            slope_next = NOW_MAX[SLOPE_W-1:0];
        end
        else if (now < NOW_MIN)
        begin
            slope_next = NOW_MIN[SLOPE_W-1:0];
        end
        else
        begin
            slope_next = now[SLOPE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= scl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && scl_valid)
        begin
            dir_reg    <= dir_next;
            slope_reg  <= slope_next;
            target_reg <= scl_data.target;
        end
    end

    assign scl_ready  = free;
    assign res_valid  = valid_reg;
    assign res_dir    = dir_reg;
    assign res_slope  = slope_reg;
    assign res_target = target_reg;

endmodule

### hw/rtl/incline_deadband_actuator.sv
// incline deadband actuator
//
// input channel (in_valid / in_ready) carries one request per accepted
// item: func selects a sensor sample (sample) or a control frame byte
// (frame_byte, frame_last). frame bytes update the target incline when a
// 13-byte set-slope frame closes and never produce an output request.
// every tenth sample closes a group; the group average is scaled to the
// current incline and compared with the target through the deadband.
// output channel (out_valid / out_ready) then carries one request with the
// motor command, drive lines, saturated current incline and target.
//
// throughput: one item per cycle while in_ready is high. after the group's
// last sample is accepted, the group is registered at that edge, then come divide by
// reciprocal, gain multiply and offset, and decide, each in its own stage.
// a stalled receiver holds the request on the output register; the stages
// behind it keep filling, and in_ready drops only once all four are full.
// reset clears the sum, count, frame state, target (0) and all valid bits,
// and loads deadband 5, gain 5073, offset 5153620.
// cfg_we writes cfg_data to register cfg_index at once (0 deadband,
// 1 gain, 2 offset); write only while no request is in flight.
module incline_deadband_actuator
    import ida_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    // configuration writes
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    // input requests
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [SAMPLE_W-1:0]        sample,
    input  logic [BYTE_W-1:0]          frame_byte,
    input  logic                       frame_last,

    // output requests
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DIR_W-1:0]           direction,
    output logic                       motor_a,
    output logic                       motor_b,
    output logic signed [SLOPE_W-1:0]  current_slope,
    output logic signed [TARGET_W-1:0] target_slope_out
);

    logic [DEADBAND_W-1:0]      deadband_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [OFFSET_W-1:0]        offset_reg;

    logic                       accepted;
    logic                       take_sample;
    logic                       take_frame;
    logic signed [TARGET_W-1:0] target;

    logic                       acc_valid;
    logic                       acc_ready;
    acc_t                       acc_data;
    logic                       scl_valid;
    logic                       scl_ready;
    scale_t                     scl_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= DEADBAND_RST;
            gain_reg     <= GAIN_RST;
            offset_reg   <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEADBAND: deadband_reg <= cfg_data[DEADBAND_W-1:0];
                REG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_OFFSET:   offset_reg   <= cfg_data[OFFSET_W-1:0];
                default:      ;
            endcase
        end
    end

    // item kind split
    assign accepted    = in_valid && in_ready;
    assign take_sample = accepted && (func == FUNC_SAMPLE);
    assign take_frame  = accepted && (func == FUNC_FRAME);

    // frame parser, holds the target in force
    ida_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take_frame),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .target     (target)
    );

    // sample accumulator, first pipeline stage
    ida_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take_sample),
        .sample    (sample),
        .target    (target),
        .free      (in_ready),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc_data  (acc_data)
    );

    // average and q16 scaling, two stages
    ida_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_valid  (acc_valid),
        .acc_ready  (acc_ready),
        .acc_data   (acc_data),
        .gain_q16   (gain_reg),
        .offset_q16 (offset_reg),
        .scl_valid  (scl_valid),
        .scl_ready  (scl_ready),
        .scl_data   (scl_data)
    );

    // deadband decision and output register
    ida_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .scl_valid  (scl_valid),
        .scl_ready  (scl_ready),
        .scl_data   (scl_data),
        .deadband   (deadband_reg),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_dir    (direction),
        .res_slope  (current_slope),
        .res_target (target_slope_out)
    );

    // drive lines follow the command
    assign motor_a = (direction == DIR_UP);
    assign motor_b = (direction == DIR_DOWN);

endmodule

### hw/rtl/ida_checker.sv
module ida_checker
    import ida_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [DIR_W-1:0]           direction,
    input  logic                       motor_a,
    input  logic                       motor_b,
    input  logic signed [SLOPE_W-1:0]  current_slope,
    input  logic signed [TARGET_W-1:0] target_slope_out
);

    // stalled request stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(direction)
            && $stable(target_slope_out) && $stable(current_slope))
        else $error("output request changed while stalled");

    // drive lines match the command
    a_lines: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_a == (direction == DIR_UP))
            && (motor_b == (direction == DIR_DOWN)))
        else $error("drive lines disagree with direction");

    // no illegal command code
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction == DIR_STOP) || (direction == DIR_UP)
            || (direction == DIR_DOWN))
        else $error("illegal direction code");

    // target never below minus the frame bias
    a_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> target_slope_out >= -$signed(TARGET_W'(SLOPE_BIAS)))
        else $error("target below minimum");

    // nothing on the output right after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output request right after reset");

endmodule

bind incline_deadband_actuator ida_checker u_ida_checker (.*);

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ida_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 10;
    // drain time after idle, with a margin on top of the output latency
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int SETTING_COUNT   = 6;
    localparam int MAX_PRINTED     = 100;

    // one input request as the driver presents it
    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] sample;
        logic [BYTE_W-1:0]   fbyte;
        logic                flast;
    } request_t;

    // one motor command as the block should emit it
    typedef struct packed {
        logic [DIR_W-1:0]           dir;
        logic                       up_line;
        logic                       down_line;
        logic signed [SLOPE_W-1:0]  slope;
        logic signed [TARGET_W-1:0] target;
    } motor_cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DEADBAND;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  func       = FUNC_SAMPLE;
    logic [SAMPLE_W-1:0]   sample     = '0;
    logic [BYTE_W-1:0]     frame_byte = '0;
    logic                  frame_last = 1'b0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [DIR_W-1:0]           direction;
    logic                       motor_a;
    logic                       motor_b;
    logic signed [SLOPE_W-1:0]  current_slope;
    logic signed [TARGET_W-1:0] target_slope_out;

    // requests waiting for the driver, commands waiting for the block
    request_t   requests_to_send[$];
    motor_cmd_t pending_cmds[$];

    int errors = 0;
    int cycles = 0;

    // register copies used by the incline predictor
    logic [DEADBAND_W-1:0] cur_deadband = DEADBAND_RST;
    logic [GAIN_W-1:0]     cur_gain     = GAIN_RST;
    logic [OFFSET_W-1:0]   cur_offset   = OFFSET_RST;

    // predictor state: sample group and frame parser
    logic [SUM_W-1:0]  grp_sum   = '0;
    int                grp_count = 0;
    logic [POS_W-1:0]  byte_pos  = '0;
    logic [BYTE_W-1:0] op_seen   = '0;
    logic [BYTE_W-1:0] slope_lo  = '0;
    logic [BYTE_W-1:0] slope_hi  = '0;
    int                target_now = 0;

    incline_deadband_actuator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .sample           (sample),
        .frame_byte       (frame_byte),
        .frame_last       (frame_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .direction        (direction),
        .motor_a          (motor_a),
        .motor_b          (motor_b),
        .current_slope    (current_slope),
        .target_slope_out (target_slope_out)
    );

    always
    begin
        #(HALF_PERIOD) clk = ~clk;
    end

    task automatic note_mismatch(string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // advance the incline state by one accepted request, queue the command it causes
    function automatic void advance_incline(request_t r);
        int         pos;
        int         avg;
        longint     prod;
        int         now;
        int         diff;
        int         shown;
        motor_cmd_t cmd;

        if (r.func == FUNC_FRAME)
        begin
            pos = int'(byte_pos);
            if (byte_pos == POS_OPCODE)     op_seen  = r.fbyte;
            if (byte_pos == POS_SLOPE_LOW)  slope_lo = r.fbyte;
            if (byte_pos == POS_SLOPE_HIGH) slope_hi = r.fbyte;
            // position saturates so overlong frames never match
            if (byte_pos != POS_MAX) pos++;
            if (r.flast)
            begin
                if (pos == FRAME_BYTES && op_seen == OPCODE_SET_SLOPE)
                    target_now = int'({slope_hi, slope_lo}) / FRAME_DIV - SLOPE_BIAS;
                byte_pos = '0;
            end
            else
                byte_pos = POS_W'(pos);
            return;
        end

        grp_sum = grp_sum + SUM_W'(r.sample);
        if (grp_count + 1 < SAMPLES_PER_DECISION)
        begin
            grp_count++;
            return;
        end

        avg       = int'(grp_sum) / SAMPLES_PER_DECISION;
        grp_sum   = '0;
        grp_count = 0;

        // q16 scaling, truncated toward zero
        prod = longint'(avg) * longint'(cur_gain) - longint'(cur_offset);
        if (prod < 0)
            now = -int'((-prod) >>> FRAC_W);
        else
            now = int'(prod >>> FRAC_W);

        // deadband uses the unsaturated incline
        diff = target_now - now;
        if (diff > int'(cur_deadband))
            cmd.dir = DIR_UP;
        else if (diff < -int'(cur_deadband))
            cmd.dir = DIR_DOWN;
        else
            cmd.dir = DIR_STOP;

        shown = now;
        if (shown > (1 <<< (SLOPE_W - 1)) - 1) shown = (1 <<< (SLOPE_W - 1)) - 1;
        if (shown < -(1 <<< (SLOPE_W - 1)))    shown = -(1 <<< (SLOPE_W - 1));

        cmd.up_line   = (cmd.dir == DIR_UP);
        cmd.down_line = (cmd.dir == DIR_DOWN);
        cmd.slope     = SLOPE_W'(shown);
        cmd.target    = TARGET_W'(target_now);
        pending_cmds.push_back(cmd);
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts of requests with random gaps in between
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        request_t next_req;

        // request taken at this edge: predict from the payload still on the pins
        if (in_valid && in_ready)
            advance_incline({func, sample, frame_byte, frame_last});

        // slot is free when nothing is shown or the shown request just went
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (requests_to_send.size() > 0)
            begin
                next_req = requests_to_send.pop_front();
                func       <= next_req.func;
                sample     <= next_req.sample;
                frame_byte <= next_req.fbyte;
                frame_last <= next_req.flast;
                in_valid   <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // a quarter of bursts run straight into the next one
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: compare each taken command, then drive the stall pattern
    // ---------------------------------------------------------------
    int ready_left = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        motor_cmd_t want;

        if (out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
                note_mismatch($sformatf("output request with none pending, direction %0d",
                                        direction));
            else
            begin
                want = pending_cmds.pop_front();
                if (direction !== want.dir)
                    note_mismatch($sformatf("direction %0d, wanted %0d", direction, want.dir));
                if (motor_a !== want.up_line)
                    note_mismatch($sformatf("motor_a %0b, wanted %0b", motor_a, want.up_line));
                if (motor_b !== want.down_line)
                    note_mismatch($sformatf("motor_b %0b, wanted %0b", motor_b, want.down_line));
                if (current_slope !== want.slope)
                    note_mismatch($sformatf("current_slope %0d, wanted %0d",
                                            current_slope, want.slope));
                if (target_slope_out !== want.target)
                    note_mismatch($sformatf("target_slope_out %0d, wanted %0d",
                                            target_slope_out, want.target));
            end
        end

        // receiver: runs of ready, then stalls of varying length
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (ready_left > 0)
                ready_left--;
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        ready_left = $urandom_range(20, 80);
                        stall_left = 0;
                    end
                    1:
                    begin
                        ready_left = $urandom_range(0, 2);
                        stall_left = $urandom_range(1, 3);
                    end
                    2:
                    begin
                        ready_left = $urandom_range(0, 10);
                        stall_left = $urandom_range(5, 20);
                    end
                    default:
                    begin
                        ready_left = $urandom_range(1, 6);
                        stall_left = $urandom_range(1, 2);
                    end
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_sample(int value);
        request_t r;
        r.func   = FUNC_SAMPLE;
        r.sample = SAMPLE_W'(value);
        // unused fields carry noise
        r.fbyte  = BYTE_W'($urandom);
        r.flast  = 1'($urandom);
        requests_to_send.push_back(r);
    endtask

    task automatic push_frame_byte(logic [BYTE_W-1:0] b, logic last);
        request_t r;
        r.func   = FUNC_FRAME;
        r.sample = SAMPLE_W'($urandom);
        r.fbyte  = b;
        r.flast  = last;
        requests_to_send.push_back(r);
    endtask

    // a frame of len bytes carrying an opcode and a raw slope word,
    // optionally with sensor samples slipped in between its bytes
    task automatic push_frame(int len, logic [BYTE_W-1:0] opcode, logic [15:0] raw,
                              bit mix_samples);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i == POS_OPCODE)
                b = opcode;
            else if (i == POS_SLOPE_LOW)
                b = raw[7:0];
            else if (i == POS_SLOPE_HIGH)
                b = raw[15:8];
            else
                b = BYTE_W'($urandom);
            push_frame_byte(b, i == len - 1);
            if (mix_samples && $urandom_range(0, 3) == 0)
                push_sample($urandom_range(0, (1 << SAMPLE_W) - 1));
        end
    endtask

    // raw slope word, mostly near the range the sensor can reach
    function automatic logic [15:0] pick_slope_word();
        int t;
        int raw;
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        if ($urandom_range(0, 9) < 7)
            t = int'($urandom_range(0, 600)) - 300;
        else
            t = int'($urandom_range(0, 6553)) - SLOPE_BIAS;
        raw = (t + SLOPE_BIAS) * FRAME_DIV + int'($urandom_range(0, FRAME_DIV - 1));
        if (raw > 65535) raw = 65535;
        return 16'(raw);
    endfunction

    task automatic build_random_requests(int n);
        int level;
        int spread;
        int v;
        int len;
        logic [BYTE_W-1:0] op;

        while (requests_to_send.size() < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // one group of samples around a level
                    level  = $urandom_range(0, (1 << SAMPLE_W) - 1);
                    spread = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 20);
                    for (int k = 0; k < SAMPLES_PER_DECISION; k++)
                    begin
                        v = level + int'($urandom_range(0, 2 * spread)) - spread;
                        if (v < 0) v = 0;
                        if (v > (1 << SAMPLE_W) - 1) v = (1 << SAMPLE_W) - 1;
                        push_sample(v);
                    end
                end
                4, 5:
                    push_frame(FRAME_BYTES, OPCODE_SET_SLOPE, pick_slope_word(),
                               $urandom_range(0, 2) == 0);
                6:
                begin
                    // right length, other opcode
                    op = BYTE_W'($urandom);
                    if (op == OPCODE_SET_SLOPE) op = op ^ 8'h01;
                    push_frame(FRAME_BYTES, op, pick_slope_word(), 1'b0);
                end
                7:
                begin
                    // short, long, and overlong frames
                    if ($urandom_range(0, 1) == 0)
                        len = $urandom_range(1, FRAME_BYTES - 1);
                    else
                        len = $urandom_range(FRAME_BYTES + 1, 40);
                    push_frame(len, OPCODE_SET_SLOPE, pick_slope_word(), 1'b0);
                end
                8:
                begin
                    // noise
                    repeat ($urandom_range(1, 8))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            push_sample($urandom_range(0, (1 << SAMPLE_W) - 1));
                        else
                            push_frame_byte(BYTE_W'($urandom), 1'($urandom));
                    end
                end
                default:
                    push_frame(FRAME_BYTES, OPCODE_SET_SLOPE, pick_slope_word(), 1'b1);
            endcase
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DEADBAND: cur_deadband = val[DEADBAND_W-1:0];
            REG_GAIN:     cur_gain     = val[GAIN_W-1:0];
            REG_OFFSET:   cur_offset   = val[OFFSET_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every request is taken and every command has come out
    task automatic wait_idle();
        do
            @(negedge clk);
        while (requests_to_send.size() != 0 || in_valid || pending_cmds.size() != 0);
        // frame bytes leave no command behind, so give the pipeline time to settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: largest target, extreme samples, then a one-byte frame
        push_frame(FRAME_BYTES, OPCODE_SET_SLOPE, 16'hFFFF, 1'b0);
        for (int k = 0; k < SAMPLES_PER_DECISION; k++)
            push_sample((k % 2 == 0) ? (1 << SAMPLE_W) - 1 : 0);
        push_frame_byte(OPCODE_SET_SLOPE, 1'b1);
        wait_idle();

        // random phases, each under its own register setting
        for (int ph = 0; ph < SETTING_COUNT; ph++)
        begin
            case (ph)
                1:
                begin
                    write_register(REG_DEADBAND, '0);
                    write_register(REG_GAIN, CFG_DATA_W'({GAIN_W{1'b1}}));
                    write_register(REG_OFFSET, '0);
                end
                2:
                begin
                    write_register(REG_DEADBAND, CFG_DATA_W'({DEADBAND_W{1'b1}}));
                    write_register(REG_GAIN, '0);
                    write_register(REG_OFFSET, CFG_DATA_W'({OFFSET_W{1'b1}}));
                end
                3:
                begin
                    write_register(REG_DEADBAND, CFG_DATA_W'($urandom_range(0, 255)));
                    write_register(REG_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
                    write_register(REG_OFFSET, CFG_DATA_W'($urandom));
                end
                4:
                begin
                    write_register(REG_DEADBAND, CFG_DATA_W'(DEADBAND_RST));
                    write_register(REG_GAIN, CFG_DATA_W'(GAIN_RST));
                    write_register(REG_OFFSET, CFG_DATA_W'(OFFSET_RST));
                end
                5:
                begin
                    write_register(REG_DEADBAND, CFG_DATA_W'($urandom_range(0, 20)));
                    write_register(REG_GAIN, CFG_DATA_W'($urandom_range(2000, 20000)));
                    write_register(REG_OFFSET, CFG_DATA_W'($urandom_range(0, 8000000)));
                end
                default: ;
            endcase
            build_random_requests(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (pending_cmds.size() != 0)
            note_mismatch($sformatf("%0d commands never came out", pending_cmds.size()));

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
